### rtl/esbp_pkg.sv
`timescale 1ns / 1ps

package esbp_pkg;

  localparam int WORD_BITS  = 64;
  localparam int OUT_WORD_W = 64;
  localparam int FILL_W     = $clog2(WORD_BITS + 1);
  localparam int CMD_W      = 3;
  localparam int SYM_W      = 8;
  localparam int WID_W      = 4;
  localparam int CODE_W     = 8;
  localparam int RUN_W      = 16;
  localparam int CNT_W      = 24;
  localparam int BLEN_W     = $clog2(RUN_W + 1);
  localparam int SR_W       = 24;
  localparam int CFG_IDX_W  = 2;

  localparam logic [RUN_W-1:0] RUN_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [WID_W-1:0] WID_MIN = 4'd3;
  localparam logic [WID_W-1:0] WID_MAX = 4'd8;

  typedef logic [CMD_W-1:0] cmd_t;
  localparam cmd_t CMD_MATCH     = 3'd0;
  localparam cmd_t CMD_MISMATCH  = 3'd1;
  localparam cmd_t CMD_DELETION  = 3'd2;
  localparam cmd_t CMD_INSERTION = 3'd3;
  localparam cmd_t CMD_FINISH    = 3'd4;

  typedef logic [1:0] op_class_t;
  localparam op_class_t CLS_NONE = 2'd0;
  localparam op_class_t CLS_SUB  = 2'd1;
  localparam op_class_t CLS_INS  = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SYMBOL_WIDTH  = 2'd0;
  localparam cfg_idx_t CFG_DELETION_CODE = 2'd1;
  localparam cfg_idx_t CFG_WILDCARD_CODE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MARK,
    S_FULL,
    S_REM,
    S_CHUNK,
    S_ELEM,
    S_FLUSH,
    S_SUM
  } seq_state_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic                 is_summary;
    logic [CNT_W-1:0]     total;
    logic [RUN_W-1:0]     run;
    logic                 ovf;
  } result_t;

  typedef struct packed {
    logic push;
    logic flush;
    logic adv;
  } pk_ctrl_t;

  typedef struct packed {
    logic ready;
    logic empty;
    logic word_done;
  } pk_stat_t;

  function automatic logic [BLEN_W-1:0] bit_length(input logic [RUN_W-1:0] v);
    logic [BLEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < RUN_W; i++) begin
      if (v[i]) begin
        n = BLEN_W'(i + 1);
      end
    end
    return n;
  endfunction

  // number of w-bit chunks needed for a value of b significant bits
  function automatic logic [2:0] chunk_count(input logic [BLEN_W-1:0] b,
                                             input logic [WID_W-1:0] w);
    logic [7:0] lim;
    logic [2:0] n;
    n = '0;
    for (int i = 0; i < 6; i++) begin
      lim = 8'(i) * {4'b0, w};
      if ({3'b0, b} > lim) begin
        n = n + 3'd1;
      end
    end
    return n;
  endfunction

endpackage

### rtl/esbp_if.sv
`timescale 1ns / 1ps

interface esbp_in_if;
  import esbp_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [SYM_W-1:0]  symbol;

  modport source (output valid, output command, output symbol, input ready);
  modport sink   (input valid, input command, input symbol, output ready);
endinterface

interface esbp_out_if;
  import esbp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OUT_WORD_W-1:0] packed_word;
  logic                  is_summary;
  logic [CNT_W-1:0]      element_total;
  logic [RUN_W-1:0]      trailing_run;
  logic                  overflow;
  logic                  last;

  modport source (output valid, output packed_word, output is_summary, output element_total,
                  output trailing_run, output overflow, output last, input ready);
  modport sink   (input valid, input packed_word, input is_summary, input element_total,
                  input trailing_run, input overflow, input last, output ready);
endinterface

### rtl/esbp_packer.sv
`timescale 1ns / 1ps

module esbp_packer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  esbp_pkg::pk_ctrl_t              ctrl,
  input  logic [esbp_pkg::CODE_W-1:0]     elem,
  input  logic [esbp_pkg::WID_W-1:0]      width,
  output esbp_pkg::pk_stat_t              stat,
  output logic [esbp_pkg::WORD_BITS-1:0]  word
);
  import esbp_pkg::*;

  logic [WORD_BITS-1:0] acc_r, acc_nxt;
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic [CODE_W-1:0]    dig_r, dig_nxt;
  logic [WID_W-1:0]     left_r, left_nxt;

  logic [CODE_W-1:0]    src_d;
  logic [WID_W-1:0]     src_left;
  logic                 flushing;
  logic                 active;
  logic [FILL_W-1:0]    avail;
  logic [WID_W-1:0]     k;
  logic [FILL_W-1:0]    fill_sum;
  logic [WORD_BITS-1:0] acc_sh;

  always_comb begin
    flushing = 1'b0;
    if (left_r != '0) begin
      src_d    = dig_r;
      src_left = left_r;
    end else if (ctrl.push) begin
      src_d    = elem << (WID_MAX - width);
      src_left = width;
    end else begin
      src_d    = '0;
      src_left = WID_MAX;
      flushing = 1'b1;
    end

    active = ctrl.adv && ((left_r != '0) || ctrl.push || (ctrl.flush && (fill_r != '0)));

    avail = FILL_W'(WORD_BITS) - fill_r;
    if (avail < FILL_W'(src_left)) begin
      k = avail[WID_W-1:0];
    end else begin
      k = src_left;
    end

    acc_sh   = (acc_r << k) | {{(WORD_BITS-CODE_W){1'b0}}, src_d >> (WID_MAX - k)};
    fill_sum = fill_r + FILL_W'(k);

    stat.ready     = (left_r == '0);
    stat.empty     = (fill_r == '0);
    stat.word_done = active && (fill_sum == FILL_W'(WORD_BITS));
    word           = acc_sh;

    acc_nxt  = acc_r;
    fill_nxt = fill_r;
    dig_nxt  = dig_r;
    left_nxt = left_r;
    if (active) begin
      acc_nxt  = acc_sh;
      fill_nxt = stat.word_done ? '0 : fill_sum;
      dig_nxt  = src_d << k;
      left_nxt = flushing ? '0 : src_left - k;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    dig_r <= dig_nxt;
    if (!rst_n) begin
      fill_r <= '0;
      left_r <= '0;
    end else begin
      fill_r <= fill_nxt;
      left_r <= left_nxt;
    end
  end

endmodule

### rtl/esbp_seq.sv
`timescale 1ns / 1ps

module esbp_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [esbp_pkg::CMD_W-1:0]   in_cmd,
  input  logic [esbp_pkg::SYM_W-1:0]   in_sym,
  input  logic [esbp_pkg::WID_W-1:0]   width,
  input  logic [esbp_pkg::CODE_W-1:0]  del_code,
  input  logic [esbp_pkg::CODE_W-1:0]  wild_code,
  input  esbp_pkg::pk_stat_t           pk_stat,
  input  logic                         can_emit,
  output esbp_pkg::pk_ctrl_t           pk_ctrl,
  output logic [esbp_pkg::CODE_W-1:0]  pk_elem,
  output logic                         sum_v,
  output esbp_pkg::result_t            sum_res,
  output logic                         ovf_now,
  output logic                         idle
);
  import esbp_pkg::*;

  seq_state_t        state_r, state_nxt;
  logic [RUN_W-1:0]  run_r, run_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;
  op_class_t         cls_r, cls_nxt;
  logic [CODE_W-1:0] elem_r, elem_nxt;
  logic [SR_W-1:0]   sr_r, sr_nxt;
  logic [2:0]        n_r, n_nxt;
  logic [1:0]        k_r, k_nxt;
  logic [CODE_W-1:0] rem_r, rem_nxt;

  logic              in_fire;
  logic              push_ok;
  logic              bump;
  op_class_t         cls_in;
  logic [CODE_W-1:0] mask;
  logic [RUN_W-1:0]  top_val;
  logic              short_run;
  logic [2:0]        n_calc;
  logic [2:0]        n_sel;
  logic [6:0]        nw;
  logic [4:0]        two_w;
  logic [4:0]        m5;
  logic [3:0]        m4;
  logic [1:0]        k_calc;
  logic [2:0]        m_calc;

  always_comb begin
    mask      = 8'hFF >> (WID_MAX - width);
    top_val   = RUN_W'(1) << (width - 4'd1);
    short_run = (run_r < top_val);
    n_calc    = chunk_count(bit_length(run_r), width);
    n_sel     = short_run ? 3'd1 : n_calc;
    nw        = {4'b0, n_sel} * {3'b0, width};
    two_w     = {width, 1'b0};
    m5        = {2'b0, n_calc} - two_w;
    m4        = {1'b0, n_calc} - width;
    if ({2'b0, n_calc} >= two_w) begin
      k_calc = 2'd2;
      m_calc = m5[2:0];
    end else if ({1'b0, n_calc} >= width) begin
      k_calc = 2'd1;
      m_calc = m4[2:0];
    end else begin
      k_calc = 2'd0;
      m_calc = n_calc;
    end
  end

  always_comb begin
    state_nxt = state_r;
    run_nxt   = run_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    cls_nxt   = cls_r;
    elem_nxt  = elem_r;
    sr_nxt    = sr_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    rem_nxt   = rem_r;

    pk_ctrl.push  = 1'b0;
    pk_ctrl.flush = 1'b0;
    pk_ctrl.adv   = can_emit;
    pk_elem       = '0;
    sum_v         = 1'b0;
    bump          = 1'b0;
    push_ok       = pk_stat.ready && can_emit;
    in_ready      = (state_r == S_IDLE) && push_ok;
    in_fire       = in_valid && in_ready;
    idle          = (state_r == S_IDLE);
    cls_in        = (in_cmd == CMD_INSERTION) ? CLS_INS : CLS_SUB;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_cmd) inside
            CMD_MATCH: begin
              cls_nxt = CLS_NONE;
              if (run_r != RUN_MAX) begin
                run_nxt = run_r + 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            CMD_MISMATCH, CMD_DELETION, CMD_INSERTION: begin
              if (in_cmd == CMD_DELETION) begin
                elem_nxt = del_code;
              end else if (in_sym == wild_code) begin
                elem_nxt = del_code - 8'd1;
              end else begin
                elem_nxt = in_sym;
              end
              if (cls_r != cls_in) begin
                cls_nxt   = cls_in;
                state_nxt = S_MARK;
              end else begin
                state_nxt = S_ELEM;
              end
            end
            CMD_FINISH: begin
              state_nxt = pk_stat.empty ? S_SUM : S_FLUSH;
            end
            default: begin
            end
          endcase
        end
      end
      S_MARK: begin
        pk_elem = del_code + {6'b0, cls_r};
        if (push_ok) begin
          pk_ctrl.push = 1'b1;
          bump         = 1'b1;
          n_nxt        = n_sel;
          k_nxt        = k_calc;
          rem_nxt      = mask ^ (mask >> m_calc);
          sr_nxt       = {{(SR_W-RUN_W){1'b0}}, run_r} << (7'(SR_W) - nw);
          run_nxt      = '0;
          if (short_run) begin
            state_nxt = S_CHUNK;
          end else if (k_calc != 2'd0) begin
            state_nxt = S_FULL;
          end else begin
            state_nxt = S_REM;
          end
        end
      end
      S_FULL: begin
        pk_elem = mask;
        if (push_ok) begin
          pk_ctrl.push = 1'b1;
          bump         = 1'b1;
          k_nxt        = k_r - 2'd1;
          if (k_r == 2'd1) begin
            state_nxt = S_REM;
          end
        end
      end
      S_REM: begin
        pk_elem = rem_r;
        if (push_ok) begin
          pk_ctrl.push = 1'b1;
          bump         = 1'b1;
          state_nxt    = S_CHUNK;
        end
      end
      S_CHUNK: begin
        pk_elem = sr_r[SR_W-1 -: CODE_W] >> (WID_MAX - width);
        if (push_ok) begin
          pk_ctrl.push = 1'b1;
          bump         = 1'b1;
          sr_nxt       = sr_r << width;
          n_nxt        = n_r - 3'd1;
          if (n_r == 3'd1) begin
            state_nxt = S_ELEM;
          end
        end
      end
      S_ELEM: begin
        pk_elem = elem_r;
        if (push_ok) begin
          pk_ctrl.push = 1'b1;
          bump         = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_FLUSH: begin
        pk_ctrl.flush = 1'b1;
        if (pk_stat.word_done) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        if (can_emit) begin
          sum_v     = 1'b1;
          run_nxt   = '0;
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          cls_nxt   = CLS_NONE;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (bump) begin
      if (cnt_r != CNT_MAX) begin
        cnt_nxt = cnt_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end

    ovf_now            = ovf_nxt;
    sum_res.word       = '0;
    sum_res.is_summary = 1'b1;
    sum_res.total      = cnt_r;
    sum_res.run        = run_r;
    sum_res.ovf        = ovf_r;
  end

  always_ff @(posedge clk) begin
    elem_r <= elem_nxt;
    sr_r   <= sr_nxt;
    n_r    <= n_nxt;
    k_r    <= k_nxt;
    rem_r  <= rem_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      run_r   <= '0;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      cls_r   <= CLS_NONE;
    end else begin
      state_r <= state_nxt;
      run_r   <= run_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      cls_r   <= cls_nxt;
    end
  end

endmodule

### rtl/esbp_outq.sv
`timescale 1ns / 1ps

module esbp_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_v,
  input  esbp_pkg::result_t  res,
  input  logic               drain,
  input  logic               out_ready,
  output logic               can_emit,
  output logic               out_valid,
  output esbp_pkg::result_t  out_res,
  output logic               out_last
);
  import esbp_pkg::*;

  result_t hold_r, hold_nxt;
  logic    hold_v_r, hold_v_nxt;
  result_t out_r, out_nxt;
  logic    out_v_r, out_v_nxt;
  logic    last_r, last_nxt;
  logic    out_free;

  // a result waits in hold until it is known whether it ends its item
  always_comb begin
    out_free   = !out_v_r || out_ready;
    can_emit   = !hold_v_r || out_free;
    hold_nxt   = hold_r;
    hold_v_nxt = hold_v_r;
    out_nxt    = out_r;
    last_nxt   = last_r;
    out_v_nxt  = out_v_r && !out_ready;

    if (res_v) begin
      if (hold_v_r) begin
        out_nxt   = hold_r;
        last_nxt  = 1'b0;
        out_v_nxt = 1'b1;
      end
      hold_nxt   = res;
      hold_v_nxt = 1'b1;
    end else if (drain && hold_v_r && out_free) begin
      out_nxt    = hold_r;
      last_nxt   = 1'b1;
      out_v_nxt  = 1'b1;
      hold_v_nxt = 1'b0;
    end

    out_valid = out_v_r;
    out_res   = out_r;
    out_last  = last_r;
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
    last_r <= last_nxt;
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

endmodule

### rtl/edit_script_bit_packer_unit.sv
// channel   dir  transfer when       payload
// in_ch     in   valid && ready      command, symbol
// out_ch    out  valid && ready      packed_word, is_summary, element_total,
//                                    trailing_run, overflow, last
// cfg_*     in   cfg_we high         cfg_index, cfg_data (no read-back)
//
// match: accept only; other edit op in the same class: accept, then one element
// class change first adds a marker and run-length elements (2 to 10 elements)
// an element split across a word boundary blocks the next accept until packed
// finish: accept, zero-fill of a partial word, then the summary
// rst_n is synchronous; config keeps its reset values 4, 5, 254 until written
// a held result with a full output register stalls the element sequencer
`timescale 1ns / 1ps

module edit_script_bit_packer_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  esbp_in_if.sink                        in_ch,
  esbp_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [esbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [esbp_pkg::CODE_W-1:0]    cfg_data
);
  import esbp_pkg::*;

  logic [WID_W-1:0]  sym_width_r;
  logic [CODE_W-1:0] del_code_r;
  logic [CODE_W-1:0] wild_code_r;
  logic [WID_W-1:0]  width_eff;

  pk_ctrl_t             pk_ctrl;
  pk_stat_t             pk_stat;
  logic [CODE_W-1:0]    pk_elem;
  logic [WORD_BITS-1:0] pk_word;
  logic                 can_emit;
  logic                 sum_v;
  result_t              sum_res;
  logic                 ovf_now;
  logic                 idle;
  logic                 res_v;
  result_t              res;
  result_t              out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_width_r <= 4'd4;
      del_code_r  <= 8'd5;
      wild_code_r <= 8'd254;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYMBOL_WIDTH:  sym_width_r <= cfg_data[WID_W-1:0];
        CFG_DELETION_CODE: del_code_r  <= cfg_data;
        CFG_WILDCARD_CODE: wild_code_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (sym_width_r < WID_MIN) begin
      width_eff = WID_MIN;
    end else if (sym_width_r > WID_MAX) begin
      width_eff = WID_MAX;
    end else begin
      width_eff = sym_width_r;
    end
  end

  esbp_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_cmd    (in_ch.command),
    .in_sym    (in_ch.symbol),
    .width     (width_eff),
    .del_code  (del_code_r),
    .wild_code (wild_code_r),
    .pk_stat   (pk_stat),
    .can_emit  (can_emit),
    .pk_ctrl   (pk_ctrl),
    .pk_elem   (pk_elem),
    .sum_v     (sum_v),
    .sum_res   (sum_res),
    .ovf_now   (ovf_now),
    .idle      (idle)
  );

  esbp_packer u_packer (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (pk_ctrl),
    .elem  (pk_elem),
    .width (width_eff),
    .stat  (pk_stat),
    .word  (pk_word)
  );

  always_comb begin
    res_v = sum_v || pk_stat.word_done;
    if (sum_v) begin
      res = sum_res;
    end else begin
      res.word       = pk_word;
      res.is_summary = 1'b0;
      res.total      = '0;
      res.run        = '0;
      res.ovf        = ovf_now;
    end
  end

  esbp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_v     (res_v),
    .res       (res),
    .drain     (idle),
    .out_ready (out_ch.ready),
    .can_emit  (can_emit),
    .out_valid (out_ch.valid),
    .out_res   (out_res),
    .out_last  (out_ch.last)
  );

  assign out_ch.packed_word   = OUT_WORD_W'(out_res.word);
  assign out_ch.is_summary    = out_res.is_summary;
  assign out_ch.element_total = out_res.total;
  assign out_ch.trailing_run  = out_res.run;
  assign out_ch.overflow      = out_res.ovf;

endmodule
